>>> hdl/ljpf_pkg.sv
// ----------------------------------------------------------------------------
// ljpf_pkg
// Shared types, codes and helpers of the Lennard-Jones pair force accumulator.
// ----------------------------------------------------------------------------
package ljpf_pkg;

    localparam int MAX_CELL_MOLECULES = 64;

    localparam int IN_DATA_W  = 336;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 152;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;

    // operations of the shared multiply-divide unit
    localparam logic [2:0] OP_A   = 3'd0;
    localparam logic [2:0] OP_B   = 3'd1;
    localparam logic [2:0] OP_T   = 3'd2;
    localparam logic [2:0] OP_Q   = 3'd3;
    localparam logic [2:0] OP_V   = 3'd4;
    localparam logic [2:0] OP_MAG = 3'd5;

    // register indexes
    localparam logic [2:0] REG_EPS   = 3'd0;
    localparam logic [2:0] REG_SIG6  = 3'd1;
    localparam logic [2:0] REG_CUT2  = 3'd2;
    localparam logic [2:0] REG_EXT_X = 3'd3;
    localparam logic [2:0] REG_EXT_Y = 3'd4;
    localparam logic [2:0] REG_EXT_Z = 3'd5;
    localparam logic [2:0] REG_RED   = 3'd6;

    typedef struct packed {
        logic [31:0]        eps;
        logic [47:0]        sig6;
        logic [31:0]        cut2;
        logic signed [47:0] ext_x;
        logic signed [47:0] ext_y;
        logic signed [47:0] ext_z;
        logic               reduced;
    } t_cfg;

    typedef struct packed {
        logic       capture;
        logic       load;
        logic       diff;
        logic       r2_add;
        logic       chk;
        logic       md_start;
        logic       op_store;
        logic       acc;
        logic       emit;
        logic [2:0] op;
        logic [1:0] comp;
    } t_cmd;

    typedef struct packed {
        logic pair_ok;
        logic md_done;
        logic md_sat;
        logic out_free;
        logic last;
    } t_sts;

    function automatic logic signed [47:0] sat48(input logic signed [56:0] v);
        logic signed [56:0] hi;
        logic signed [56:0] lo;
        hi = 57'sh7FFF_FFFF_FFFF;
        lo = -57'sh8000_0000_0000;
        if (v > hi) begin
            sat48 = 48'sh7FFF_FFFF_FFFF;
        end else if (v < lo) begin
            sat48 = 48'sh8000_0000_0000;
        end else begin
            sat48 = v[47:0];
        end
    endfunction

endpackage

>>> hdl/ljpf_muldiv.sv
// ----------------------------------------------------------------------------
// ljpf_muldiv
// Iterative floor(a*b/c): 64x64 product from four 32x32 partial products,
// then restoring division one bit a cycle, or a fixed shift by 32 bits.
// ----------------------------------------------------------------------------
module ljpf_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [47:0] i_c,
    input  logic        i_shift,
    output logic        o_busy,
    output logic        o_done,
    output logic [61:0] o_q,
    output logic        o_sat
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]   r_ph, n_ph;
    logic [6:0]   r_cnt;
    logic [63:0]  r_a, r_b, r_pp;
    logic [47:0]  r_c, r_rem;
    logic [127:0] r_p;
    logic         r_shift;

    logic [31:0]  a_part, b_part;
    logic [1:0]   prev;
    logic [1:0]   sh;
    logic [127:0] addend;
    logic [48:0]  rem_sh;
    logic         ge;

    always_comb begin
        a_part = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        b_part = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        prev   = r_cnt[1:0] - 2'd1;
        sh     = {1'b0, prev[1]} + {1'b0, prev[0]};
        case (sh)
            2'd0:    addend = {64'b0, r_pp};
            2'd1:    addend = {32'b0, r_pp, 32'b0};
            2'd2:    addend = {r_pp, 64'b0};
            default: addend = '0;
        endcase
        rem_sh = {r_rem, r_p[127]};
        ge     = rem_sh >= {1'b0, r_c};
    end

    always_comb begin
        n_ph = r_ph;
        case (r_ph)
            PH_IDLE: if (i_start) n_ph = PH_MUL;
            PH_MUL:  if (r_cnt == 7'd4) n_ph = r_shift ? PH_FIN : PH_DIV;
            PH_DIV:  if (r_cnt == 7'd127) n_ph = PH_FIN;
            PH_FIN:  n_ph = PH_IDLE;
            default: n_ph = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
        end else begin
            r_ph <= n_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_ph)
            PH_IDLE: begin
                if (i_start) begin
                    r_a     <= i_a;
                    r_b     <= i_b;
                    r_c     <= i_c;
                    r_shift <= i_shift;
                    r_p     <= '0;
                    r_cnt   <= '0;
                end
            end
            PH_MUL: begin
                if (r_cnt < 7'd4) r_pp <= a_part * b_part;
                if (r_cnt != 7'd0) r_p <= r_p + addend;
                if (r_cnt == 7'd4) begin
                    r_cnt <= '0;
                    r_rem <= '0;
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            PH_DIV: begin
                r_rem <= ge ? 48'(rem_sh - {1'b0, r_c}) : rem_sh[47:0];
                r_p   <= {r_p[126:0], ge};
                r_cnt <= r_cnt + 7'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_busy = r_ph != PH_IDLE;
    assign o_done = r_ph == PH_FIN;
    assign o_q    = r_shift ? r_p[93:32] : r_p[61:0];
    assign o_sat  = r_shift ? |r_p[127:94] : |r_p[127:62];

endmodule

>>> hdl/ljpf_datapath.sv
// ----------------------------------------------------------------------------
// ljpf_datapath
// Item registers, difference vector, r2, pair force chain, saturating
// accumulators, pair counter and the output register.
// ----------------------------------------------------------------------------
module ljpf_datapath #(
    parameter int MAX_CELL_MOLECULES = ljpf_pkg::MAX_CELL_MOLECULES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ljpf_pkg::t_cfg                    i_cfg,
    input  ljpf_pkg::t_cmd                    i_cmd,
    output ljpf_pkg::t_sts                    o_sts,
    input  logic [ljpf_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic [ljpf_pkg::IN_USER_W-1:0]    i_s_tuser,
    input  logic                              i_s_tlast,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [ljpf_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import ljpf_pkg::*;

    localparam int LIM = (MAX_CELL_MOLECULES < 127) ? MAX_CELL_MOLECULES : 127;
    localparam logic [6:0] CNT_LIM = 7'(LIM);

    logic signed [31:0] r_own [0:2];
    logic signed [31:0] r_oth [0:2];
    logic signed [47:0] r_prior [0:2];
    logic signed [47:0] r_acc [0:2];
    logic [23:0]        r_ad [0:2];
    logic [2:0]         r_dneg;
    logic               r_has, r_first, r_last, r_far;
    logic [49:0]        r_r2;
    logic [6:0]         r_cnt;
    logic [61:0]        r_x;
    logic [62:0]        r_v;
    logic               r_rep, r_sat;
    logic               r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic signed [32:0] d [0:2];
    logic [32:0]        dabs [0:2];
    logic [31:0]        e;
    logic [47:0]        s;
    logic [36:0]        e24;
    logic [47:0]        sq;
    logic               pair_ok, out_free;
    logic [63:0]        md_a, md_b;
    logic               md_shift, md_busy, md_done, md_sat;
    logic [61:0]        md_q;
    logic [62:0]        t63, q2;
    logic [53:0]        mag;
    logic               neg;
    logic signed [56:0] add;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            d[c]    = 33'(r_oth[c]) - 33'(r_own[c]);
            dabs[c] = d[c][32] ? 33'(-d[c]) : 33'(d[c]);
        end
        e        = i_cfg.reduced ? 32'd65536 : i_cfg.eps;
        s        = i_cfg.reduced ? 48'd65536 : i_cfg.sig6;
        e24      = {1'b0, e, 4'b0} + {2'b0, e, 3'b0};
        sq       = r_ad[i_cmd.comp] * r_ad[i_cmd.comp];
        pair_ok  = r_has && !r_far && (r_r2 != '0) && (r_r2 <= {2'b0, i_cfg.cut2, 16'b0});
        out_free = !r_ovalid || i_m_tready;
        t63      = {1'b0, r_x};
        q2       = {md_q, 1'b0};
    end

    always_comb begin
        md_a     = {2'b0, r_x};
        md_b     = 64'h1_0000_0000;
        md_shift = 1'b0;
        case (i_cmd.op)
            OP_A: begin
                md_a = {16'b0, s};
                md_b = 64'h0001_0000_0000_0000;
            end
            OP_B, OP_T: begin
            end
            OP_Q: begin
                md_b     = {2'b0, r_x};
                md_shift = 1'b1;
            end
            OP_V: begin
                md_a = {1'b0, r_v};
                md_b = {11'b0, e24, 16'b0};
            end
            OP_MAG: begin
                md_a     = {1'b0, r_v};
                md_b     = {40'b0, r_ad[i_cmd.comp]};
                md_shift = 1'b1;
            end
            default: begin
            end
        endcase
    end

    ljpf_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.md_start),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_c     (r_r2[47:0]),
        .i_shift (md_shift),
        .o_busy  (md_busy),
        .o_done  (md_done),
        .o_q     (md_q),
        .o_sat   (md_sat)
    );

    // overlap drives a fixed magnitude against each nonzero component
    always_comb begin
        if (r_sat) begin
            mag = ((e != '0) && (r_ad[i_cmd.comp] != '0)) ? 54'(1) << 47 : '0;
        end else begin
            mag = md_q[53:0];
        end
        neg = r_rep ^ r_dneg[i_cmd.comp];
        add = neg ? -57'(mag) : 57'(mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int c = 0; c < 3; c++) begin
                r_own[c]   <= $signed(i_s_tdata[32*c +: 32]);
                r_oth[c]   <= $signed(i_s_tdata[96 + 32*c +: 32]);
                r_prior[c] <= $signed(i_s_tdata[192 + 48*c +: 48]);
            end
            r_has   <= i_s_tuser[0];
            r_first <= i_s_tuser[1];
            r_last  <= i_s_tlast;
        end
        if (i_cmd.diff) begin
            for (int c = 0; c < 3; c++) begin
                r_ad[c]   <= dabs[c][23:0];
                r_dneg[c] <= d[c][32];
            end
            r_far <= |dabs[0][32:24] || |dabs[1][32:24] || |dabs[2][32:24];
            r_r2  <= '0;
        end
        if (i_cmd.r2_add) r_r2 <= r_r2 + 50'(sq);
        if (i_cmd.chk) begin
            r_rep <= 1'b1;
            r_sat <= 1'b0;
        end
        if (i_cmd.op_store) begin
            if (md_sat) r_sat <= 1'b1;
            case (i_cmd.op)
                OP_A, OP_B, OP_T: r_x <= md_q;
                OP_Q: begin
                    // a saturated square leaves the repulsive sign in place
                    if (!md_sat) begin
                        if (t63 >= q2) begin
                            r_v   <= t63 - q2;
                            r_rep <= 1'b0;
                        end else begin
                            r_v   <= q2 - t63;
                            r_rep <= 1'b1;
                        end
                    end
                end
                OP_V:    r_v <= {1'b0, md_q};
                default: begin
                end
            endcase
        end
        if (i_cmd.emit) begin
            r_odata <= {1'b0, r_cnt, r_acc[2], r_acc[1], r_acc[0]};
        end
    end

    // accumulators and the pair count are architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) r_acc[c] <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load && r_first) begin
                r_acc[0] <= sat48(57'(r_prior[0]) + 57'(i_cfg.ext_x));
                r_acc[1] <= sat48(57'(r_prior[1]) + 57'(i_cfg.ext_y));
                r_acc[2] <= sat48(57'(r_prior[2]) + 57'(i_cfg.ext_z));
                r_cnt    <= '0;
            end
            if (i_cmd.chk && pair_ok && (r_cnt < CNT_LIM)) r_cnt <= r_cnt + 7'd1;
            if (i_cmd.acc) begin
                r_acc[i_cmd.comp] <= sat48(57'(r_acc[i_cmd.comp]) + add);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.pair_ok  = pair_ok;
    assign o_sts.md_done  = md_done;
    assign o_sts.md_sat   = md_sat;
    assign o_sts.out_free = out_free;
    assign o_sts.last     = r_last;
    assign o_m_tvalid     = r_ovalid;
    assign o_m_tdata      = r_odata;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free) else $error("emit while output register is full");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.md_start |-> !md_busy) else $error("multiply-divide started while busy");
    a_cnt_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LIM) else $error("pair count beyond limit");
    a_acc_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.acc && !r_sat) |-> md_done) else $error("accumulate without a magnitude");

endmodule

>>> hdl/ljpf_ctrl.sv
// ----------------------------------------------------------------------------
// ljpf_ctrl
// Sequencer: accept, load, difference, r2, cutoff check, the quotient chain
// on the multiply-divide unit, the three component adds and the emit.
// ----------------------------------------------------------------------------
module ljpf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  ljpf_pkg::t_sts i_sts,
    output ljpf_pkg::t_cmd o_cmd
);
    import ljpf_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LOAD = 4'd1;
    localparam logic [3:0] ST_DIFF = 4'd2;
    localparam logic [3:0] ST_R2   = 4'd3;
    localparam logic [3:0] ST_CHK  = 4'd4;
    localparam logic [3:0] ST_OPST = 4'd5;
    localparam logic [3:0] ST_OPW  = 4'd6;
    localparam logic [3:0] ST_MST  = 4'd7;
    localparam logic [3:0] ST_MW   = 4'd8;
    localparam logic [3:0] ST_ACC  = 4'd9;
    localparam logic [3:0] ST_EMIT = 4'd10;

    logic [3:0] r_state, n_state;
    logic [2:0] r_op, n_op;
    logic [1:0] r_comp, n_comp;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_comp     = r_comp;
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_cmd.comp = r_comp;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_comp     = 2'd0;
                n_state    = ST_R2;
            end
            ST_R2: begin
                o_cmd.r2_add = 1'b1;
                if (r_comp == 2'd2) begin
                    n_comp  = 2'd0;
                    n_state = ST_CHK;
                end else begin
                    n_comp = r_comp + 2'd1;
                end
            end
            ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_op      = OP_A;
                n_state   = i_sts.pair_ok ? ST_OPST : ST_EMIT;
            end
            ST_OPST: begin
                o_cmd.md_start = 1'b1;
                n_state        = ST_OPW;
            end
            ST_OPW: begin
                if (i_sts.md_done) begin
                    o_cmd.op_store = 1'b1;
                    n_comp         = 2'd0;
                    if (i_sts.md_sat) begin
                        n_state = ST_ACC;
                    end else if (r_op == OP_V) begin
                        n_op    = OP_MAG;
                        n_state = ST_MST;
                    end else begin
                        n_op    = r_op + 3'd1;
                        n_state = ST_OPST;
                    end
                end
            end
            ST_MST: begin
                o_cmd.md_start = 1'b1;
                n_state        = ST_MW;
            end
            ST_MW: begin
                if (i_sts.md_done) begin
                    o_cmd.acc = 1'b1;
                    if (r_comp == 2'd2) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = ST_MST;
                    end
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_comp == 2'd2) begin
                    n_state = ST_EMIT;
                end else begin
                    n_comp = r_comp + 2'd1;
                end
            end
            ST_EMIT: begin
                if (!i_sts.last) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_A;
            r_comp  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_comp  <= n_comp;
        end
    end

endmodule

>>> hdl/lennard_jones_pair_force_accumulator.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_accumulator
// 12-6 Lennard-Jones force on one molecule, accumulated over a neighbor stream.
// ----------------------------------------------------------------------------
// One request at a time. A pair inside the cutoff runs the quotient chain on
// the shared multiply-divide unit: four 128-step divisions plus four shifted
// products (an overlap skips the rest of the chain at its first saturation).
// The result of a tlast request loads the output register and waits there while
// the next request is accepted. Synchronous active-low reset clears accumulators,
// pair count, control and output valid, and sets the registers to their defaults.
module lennard_jones_pair_force_accumulator #(
    parameter int MAX_CELL_MOLECULES = ljpf_pkg::MAX_CELL_MOLECULES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // own_x, own_y, own_z, other_x, other_y, other_z, prior_fx, prior_fy, prior_fz
    input  logic [ljpf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // has_neighbor, first_neighbor
    input  logic [ljpf_pkg::IN_USER_W-1:0]   s_axis_tuser,
    input  logic                             s_axis_tlast,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // force_x, force_y, force_z, pairs_within_cutoff, one zero pad bit
    output logic [ljpf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ljpf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ljpf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ljpf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import ljpf_pkg::*;

    logic [31:0]        r_eps;
    logic [47:0]        r_sig6;
    logic [31:0]        r_cut2;
    logic signed [47:0] r_ext_x, r_ext_y, r_ext_z;
    logic               r_red;

    logic       wr_en;
    logic [2:0] reg_idx;
    t_cfg       cfg;
    t_cmd       cmd;
    t_sts       sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps   <= 32'd65536;
            r_sig6  <= 48'd65536;
            r_cut2  <= 32'd6291456;
            r_ext_x <= '0;
            r_ext_y <= '0;
            r_ext_z <= '0;
            r_red   <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_EPS:   r_eps   <= pwdata[31:0];
                REG_SIG6:  r_sig6  <= pwdata[47:0];
                REG_CUT2:  r_cut2  <= pwdata[31:0];
                REG_EXT_X: r_ext_x <= pwdata[47:0];
                REG_EXT_Y: r_ext_y <= pwdata[47:0];
                REG_EXT_Z: r_ext_z <= pwdata[47:0];
                REG_RED:   r_red   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_EPS:   prdata = {32'b0, r_eps};
            REG_SIG6:  prdata = {16'b0, r_sig6};
            REG_CUT2:  prdata = {32'b0, r_cut2};
            REG_EXT_X: prdata = {16'b0, r_ext_x};
            REG_EXT_Y: prdata = {16'b0, r_ext_y};
            REG_EXT_Z: prdata = {16'b0, r_ext_z};
            REG_RED:   prdata = {63'b0, r_red};
            default:   prdata = '0;
        endcase
    end

    assign cfg.eps     = r_eps;
    assign cfg.sig6    = r_sig6;
    assign cfg.cut2    = r_cut2;
    assign cfg.ext_x   = r_ext_x;
    assign cfg.ext_y   = r_ext_y;
    assign cfg.ext_z   = r_ext_z;
    assign cfg.reduced = r_red;

    ljpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ljpf_datapath #(
        .MAX_CELL_MOLECULES (MAX_CELL_MOLECULES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule
